@@ sv/bf3_pkg.sv @@
// shared constants and types for the 3x3 box filter
// no dependencies; compiled first
package bf3_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 8;

   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 12;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int MEAN_BITS      = 8;

   localparam int DIVISOR        = 9;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 12'd480;

   localparam logic [HEIGHT_BITS-1:0] MIN_SIZE = 12'd3;

   // per-pixel tag: does this pixel complete a window, is it the frame's last result
   typedef struct packed {
      logic emit;
      logic last;
   } bf3_tag_type;

endpackage

@@ sv/bf3_if.sv @@
// stream channel interfaces for the 3x3 box filter: pixel input and mean output
// depends on bf3_pkg
interface bf3_req_if #(
   parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bf3_rsp_if ();
   logic                          valid;
   logic                          ready;
   logic [bf3_pkg::MEAN_BITS-1:0] mean_out;
   logic                          frame_last;

   modport source (output valid, output mean_out, output frame_last, input ready);
   modport sink   (input valid, input mean_out, input frame_last, output ready);
endinterface

@@ sv/box_filter_3x3_mean_unit.sv @@
// 3x3 box filter top level: config registers, pipeline control, channel ports
// depends on bf3_pkg, bf3_if, bf3_pos_ctrl, bf3_line_store, bf3_window_mean

// Streaming 3x3 mean filter. Pixels enter one beat per cycle in raster order and
// a new pixel is taken every cycle while the output side keeps up; the sustained
// rate of one pixel per cycle is set by the two line memories, each doing one read
// and one write per cycle. Only interior windows give a result, (width-2) by
// (height-2) per frame, the last flagged with frame_last; a result passes the s1,
// s2, s3 and output registers after the pixel that completes its window. Width is
// clamped to 3..MAX_WIDTH and height to at least 3. The line memories need no clearing
// after reset: rows 0 and 1 of each frame never produce results from stale contents.
// The user must write registers only while the filter is idle; it is not enforced.
module box_filter_3x3_mean_unit #(
   parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   bf3_req_if.sink                            req_chan,
   bf3_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [bf3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bf3_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import bf3_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);

   logic [WIDTH_BITS-1:0]  image_width_ff;
   logic [HEIGHT_BITS-1:0] image_height_ff;

   logic                  advance, accept, out_valid;
   logic [COL_BITS-1:0]   pos_addr;
   bf3_tag_type           pos_tag;

   logic                  s1_valid_ff;
   bf3_tag_type           s1_tag_ff;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic [COL_BITS-1:0]   s1_addr_ff;
   logic                  wr_en;
   logic [PIXEL_BITS-1:0] upper_rd, middle_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_wr_data[WIDTH_BITS-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wr_data[HEIGHT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // whole pipeline moves together; bubbles drain whenever the output is free
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;
   assign wr_en          = s1_valid_ff && advance;

   bf3_pos_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .COL_BITS  (COL_BITS)
   ) u_pos (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .cfg_width  (image_width_ff),
      .cfg_height (image_height_ff),
      .addr       (pos_addr),
      .tag        (pos_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff   <= pos_tag;
         s1_pixel_ff <= req_chan.pixel_in;
         s1_addr_ff  <= pos_addr;
      end
   end

   // consecutive beats always hit different columns, so a read never meets
   // the write-back of the same entry
   bf3_line_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS),
      .COL_BITS   (COL_BITS)
   ) u_lines (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (pos_addr),
      .wr_en     (wr_en),
      .wr_addr   (s1_addr_ff),
      .wr_pixel  (s1_pixel_ff),
      .upper_rd  (upper_rd),
      .middle_rd (middle_rd)
   );

   bf3_window_mean #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s1_valid_ff),
      .in_tag    (s1_tag_ff),
      .pixel     (s1_pixel_ff),
      .upper     (upper_rd),
      .middle    (middle_rd),
      .out_valid (out_valid),
      .out_mean  (rsp_chan.mean_out),
      .out_last  (rsp_chan.frame_last)
   );

   assign rsp_chan.valid = out_valid;

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept) |-> (s1_addr_ff != pos_addr))
      else $error("line store read and write-back hit the same column");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while a result is stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_chan.valid && !s1_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

@@ sv/bf3_pos_ctrl.sv @@
// raster position counters: column and row, with line and frame wrap
// depends on bf3_pkg; gives the line store address and the per-pixel tag
module bf3_pos_ctrl #(
   parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF,
   parameter int COL_BITS  = $clog2(MAX_WIDTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [bf3_pkg::WIDTH_BITS-1:0]  cfg_width,
   input  logic [bf3_pkg::HEIGHT_BITS-1:0] cfg_height,
   output logic [COL_BITS-1:0]             addr,
   output bf3_pkg::bf3_tag_type            tag
);
   import bf3_pkg::*;

   localparam int WB   = (WIDTH_BITS > COL_BITS + 1) ? WIDTH_BITS : COL_BITS + 1;
   localparam int CMPB = WB + 1;
   localparam logic [CMPB-1:0] MAX_W = CMPB'(MAX_WIDTH);
   localparam logic [CMPB-1:0] MIN_W = CMPB'(3);

   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [CMPB-1:0]        width_ext, eff_w, col_plus;
   logic [HEIGHT_BITS-1:0] eff_h;
   logic [HEIGHT_BITS:0]   row_plus;
   logic                   last_col, last_row;

   always_comb begin
      width_ext = CMPB'(cfg_width);
      if (width_ext < MIN_W) begin
         eff_w = MIN_W;
      end else if (width_ext > MAX_W) begin
         eff_w = MAX_W;
      end else begin
         eff_w = width_ext;
      end
      eff_h    = (cfg_height < MIN_SIZE) ? MIN_SIZE : cfg_height;
      col_plus = CMPB'(col_ff) + CMPB'(1);
      row_plus = {1'b0, row_ff} + (HEIGHT_BITS+1)'(1);
      // a counter past a shrunken limit counts as last and wraps
      last_col = (col_plus >= eff_w);
      last_row = (row_plus >= {1'b0, eff_h});
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_plus[HEIGHT_BITS-1:0];
         end else begin
            col_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign addr     = col_ff;
   assign tag.emit = (CMPB'(col_ff) >= CMPB'(2)) && (row_ff >= HEIGHT_BITS'(2));
   assign tag.last = last_col && last_row;

endmodule

@@ sv/bf3_line_store.sv @@
// two line memories holding the previous two rows, one read and one write per cycle each
// depends on bf3_pkg; read data is registered
module bf3_line_store #(
   parameter int MAX_WIDTH  = bf3_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF,
   parameter int COL_BITS   = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [COL_BITS-1:0]   rd_addr,
   input  logic                  wr_en,
   input  logic [COL_BITS-1:0]   wr_addr,
   input  logic [PIXEL_BITS-1:0] wr_pixel,
   output logic [PIXEL_BITS-1:0] upper_rd,
   output logic [PIXEL_BITS-1:0] middle_rd
);
   import bf3_pkg::*;

   logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] upper_rd_ff, middle_rd_ff;

   // read data holds while stalled, so the pending beat keeps its rows
   always_ff @(posedge clock) begin
      if (rd_en) begin
         upper_rd_ff  <= upper_mem[rd_addr];
         middle_rd_ff <= middle_mem[rd_addr];
      end
   end

   // the middle row moves up, the new pixel becomes the middle row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= middle_rd_ff;
         middle_mem[wr_addr] <= wr_pixel;
      end
   end

   assign upper_rd  = upper_rd_ff;
   assign middle_rd = middle_rd_ff;

endmodule

@@ sv/bf3_window_mean.sv @@
// 3x3 window registers, nine-pixel sum and divide by nine by reciprocal multiply
// depends on bf3_pkg; three register stages ending in the output register
module bf3_window_mean #(
   parameter int PIXEL_BITS = bf3_pkg::PIXEL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  bf3_pkg::bf3_tag_type          in_tag,
   input  logic [PIXEL_BITS-1:0]         pixel,
   input  logic [PIXEL_BITS-1:0]         upper,
   input  logic [PIXEL_BITS-1:0]         middle,
   output logic                          out_valid,
   output logic [bf3_pkg::MEAN_BITS-1:0] out_mean,
   output logic                          out_last
);
   import bf3_pkg::*;

   localparam int SUM_BITS = PIXEL_BITS + 4;
   localparam int QW       = (SUM_BITS > MEAN_BITS) ? SUM_BITS : MEAN_BITS;
   // floor of 2^QW / 9: quotient is exact or one low, fixed by one compare
   localparam logic [QW-1:0] RECIP = QW'((64'd1 << QW) / DIVISOR);
   localparam logic [QW-1:0] DIV_Q = QW'(DIVISOR);

   logic [PIXEL_BITS-1:0] win_ff [6];
   logic [SUM_BITS-1:0]   sum_in;

   logic                  s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                  s2_last_ff, s3_last_ff, out_last_ff;
   logic [QW-1:0]         s2_sum_ff, s3_sum_ff;
   logic [2*QW-1:0]       s3_prod_ff;
   logic [QW-1:0]         q_est, rem, q_fix;
   logic [MEAN_BITS-1:0]  out_mean_ff;

   always_comb begin
      sum_in = SUM_BITS'(pixel) + SUM_BITS'(upper) + SUM_BITS'(middle);
      for (int i = 0; i < 6; i++) begin
         sum_in = sum_in + SUM_BITS'(win_ff[i]);
      end
   end

   // window columns: taps 0..2 hold column c-2, 3..5 column c-1, top to bottom
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance && in_valid) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= upper;
         win_ff[4] <= middle;
         win_ff[5] <= pixel;
      end
   end

   always_comb begin
      q_est = s3_prod_ff[2*QW-1:QW];
      rem   = s3_sum_ff - q_est * DIV_Q;
      q_fix = (rem >= DIV_Q) ? q_est + QW'(1) : q_est;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= in_valid && in_tag.emit;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff   <= QW'(sum_in);
         s2_last_ff  <= in_tag.last;
         s3_sum_ff   <= s2_sum_ff;
         s3_prod_ff  <= s2_sum_ff * RECIP;
         s3_last_ff  <= s2_last_ff;
         out_mean_ff <= q_fix[MEAN_BITS-1:0];
         out_last_ff <= s3_last_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_mean  = out_mean_ff;
   assign out_last  = out_last_ff;

endmodule

@@ tb/bf3_mean_checker.sv @@
`timescale 1ns / 100ps
// checker for the 3x3 box filter: watches the pixel, mean and register ports,
// predicts each mean beat and compares; depends on bf3_pkg and bf3_if
module bf3_mean_checker #(
   parameter int MAX_WIDTH = bf3_pkg::MAX_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   bf3_req_if                                 req_mon,
   bf3_rsp_if                                 rsp_mon,
   input  logic                               csr_wr_en,
   input  logic [bf3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bf3_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                                 fail_count,
   output int                                 pending_count
);
   import bf3_pkg::*;

   localparam int PIX        = PIXEL_BITS_DEF;
   localparam int SHOW_LIMIT = 10;

   typedef struct packed {
      logic [MEAN_BITS-1:0] mean;
      logic                 last;
   } mean_beat_type;

   logic [WIDTH_BITS-1:0]  width_reg;
   logic [HEIGHT_BITS-1:0] height_reg;
   bit   [PIX-1:0]         upper_line  [MAX_WIDTH];
   bit   [PIX-1:0]         middle_line [MAX_WIDTH];
   bit   [PIX-1:0]         window_taps [6];
   int unsigned            col_pos;
   int unsigned            row_pos;
   mean_beat_type          expected_means [$];
   int                     mismatches;

   function automatic int unsigned clamp_width(logic [WIDTH_BITS-1:0] w);
      if (w < 3) return 3;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   function automatic int unsigned clamp_height(logic [HEIGHT_BITS-1:0] h);
      if (h < 3) return 3;
      return h;
   endfunction

   function void predict_mean(logic [PIX-1:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      int unsigned total;
      bit [PIX-1:0] up;
      bit [PIX-1:0] mid;
      bit           end_of_line;
      bit           end_of_frame;
      mean_beat_type beat;
      w            = clamp_width(width_reg);
      h            = clamp_height(height_reg);
      slot         = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
      up           = upper_line[slot];
      mid          = middle_line[slot];
      end_of_line  = (col_pos + 1 >= w);
      end_of_frame = (row_pos + 1 >= h);
      upper_line[slot]  = mid;
      middle_line[slot] = px;
      // window centred one row up and one column left is complete here
      if (col_pos >= 2 && row_pos >= 2) begin
         total = up + mid + px;
         for (int i = 0; i < 6; i++) total += window_taps[i];
         beat.mean = MEAN_BITS'(total / DIVISOR);
         beat.last = end_of_line && end_of_frame;
         expected_means.push_back(beat);
      end
      window_taps[0] = window_taps[3];
      window_taps[1] = window_taps[4];
      window_taps[2] = window_taps[5];
      window_taps[3] = up;
      window_taps[4] = mid;
      window_taps[5] = px;
      if (end_of_line) begin
         col_pos = 0;
         row_pos = end_of_frame ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function void compare_mean(logic [MEAN_BITS-1:0] got_mean, logic got_last);
      mean_beat_type want;
      if (expected_means.size() == 0) begin
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("mean beat with none expected: got mean %0d last %0b", got_mean, got_last);
         return;
      end
      want = expected_means.pop_front();
      if (got_mean !== want.mean || got_last !== want.last) begin
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("mean mismatch: expected mean %0d last %0b, got mean %0d last %0b",
                     want.mean, want.last, got_mean, got_last);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_pos    = 0;
         row_pos    = 0;
         for (int i = 0; i < 6; i++) window_taps[i] = '0;
         expected_means.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_reg = csr_wr_data[WIDTH_BITS-1:0];
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = csr_wr_data[HEIGHT_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_mon.valid && req_mon.ready) predict_mean(req_mon.pixel_in);
         if (rsp_mon.valid && rsp_mon.ready) compare_mean(rsp_mon.mean_out, rsp_mon.frame_last);
      end
      fail_count    <= mismatches;
      pending_count <= expected_means.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// top of the 3x3 box filter bench: clock, reset, pixel frames, register writes
// and the verdict; depends on bf3_pkg, bf3_if, the filter and bf3_mean_checker
module tb;
   import bf3_pkg::*;

   localparam int PHASE_ITEMS   = 270;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum {
      PIX_UNIFORM,
      PIX_EXTREME,
      PIX_BRIGHT,
      PIX_DARK,
      PIX_SATURATED
   } pixel_mix_type;

   typedef struct {
      int unsigned               at_pixel;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [CSR_DATA_BITS-1:0]  data;
   } reg_change_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;
   int                        fail_count;
   int                        pending_count;
   int                        cycles;
   int                        send_gap_pct;
   int                        stall_pct;
   int unsigned               items_sent;

   // where the filter stands in its frame, and how often each column was written
   logic [WIDTH_BITS-1:0]     width_set;
   logic [HEIGHT_BITS-1:0]    height_set;
   int unsigned               col_at;
   int unsigned               row_at;
   bit [1:0]                  col_writes [MAX_WIDTH_DEF];
   reg_change_type            reg_changes [$];

   bf3_req_if req_bus ();
   bf3_rsp_if rsp_bus ();

   box_filter_3x3_mean_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   bf3_mean_checker i_mean_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("box_filter_3x3_mean_unit verification failed");
         $finish;
      end
   end

   function automatic int unsigned eff_width(logic [WIDTH_BITS-1:0] w);
      if (w < 3) return 3;
      if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return w;
   endfunction

   function automatic int unsigned eff_height(logic [HEIGHT_BITS-1:0] h);
      if (h < 3) return 3;
      return h;
   endfunction

   function void advance_position();
      if (col_writes[col_at] != 2'd2) col_writes[col_at]++;
      if (col_at + 1 >= eff_width(width_set)) begin
         col_at = 0;
         row_at = (row_at + 1 >= eff_height(height_set)) ? 0 : row_at + 1;
      end else begin
         col_at++;
      end
   endfunction

   // a line-store column is safe to read once both stores have been written there
   function automatic logic [CSR_DATA_BITS-1:0] guard_width(logic [CSR_DATA_BITS-1:0] data);
      int unsigned reach;
      int unsigned want;
      reach = 0;
      while (reach < MAX_WIDTH_DEF && col_writes[reach] == 2'd2) reach++;
      want = eff_width(data[WIDTH_BITS-1:0]);
      if (want <= eff_width(width_set) || want <= reach) return data;
      if (reach > eff_width(width_set)) return CSR_DATA_BITS'(reach);
      return CSR_DATA_BITS'(width_set);
   endfunction

   function automatic logic [PIXEL_BITS_DEF-1:0] make_pixel(pixel_mix_type mix);
      case (mix)
         PIX_EXTREME:   return $urandom_range(1) ? 8'hFF : 8'h00;
         PIX_BRIGHT:    return PIXEL_BITS_DEF'($urandom_range(255, 240));
         PIX_DARK:      return PIXEL_BITS_DEF'($urandom_range(15));
         PIX_SATURATED: return 8'hFF;
         default:       return PIXEL_BITS_DEF'($urandom_range(255));
      endcase
   endfunction

   task automatic push_pixel(input logic [PIXEL_BITS_DEF-1:0] px);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.pixel_in <= px;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      advance_position();
   endtask

   // stop sending, let every expected mean arrive, then allow the pipeline to empty
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      if (idx == REG_IMAGE_WIDTH) width_set = data[WIDTH_BITS-1:0];
      else height_set = data[HEIGHT_BITS-1:0];
   endtask

   task automatic run_frame(input logic [CSR_DATA_BITS-1:0] width_data,
                            input logic [CSR_DATA_BITS-1:0] height_data,
                            input pixel_mix_type mix);
      int unsigned n;
      reg_change_type chg;
      drain();
      write_reg(REG_IMAGE_WIDTH, width_data);
      write_reg(REG_IMAGE_HEIGHT, height_data);
      csr_wr_en <= 1'b0;
      n = 0;
      do begin
         if (reg_changes.size() != 0 && reg_changes[0].at_pixel == n) begin
            drain();
            while (reg_changes.size() != 0 && reg_changes[0].at_pixel == n) begin
               chg = reg_changes.pop_front();
               if (chg.idx == REG_IMAGE_WIDTH) write_reg(chg.idx, guard_width(chg.data));
               else write_reg(chg.idx, chg.data);
            end
            csr_wr_en <= 1'b0;
         end
         push_pixel(make_pixel(mix));
         n++;
      end while (col_at != 0 || row_at != 0);
      reg_changes.delete();
   endtask

   initial begin
      int unsigned        small_items;
      int unsigned        mark;
      int unsigned        phase;
      int unsigned        w_pick;
      int unsigned        h_pick;
      int unsigned        span;
      bit                 wide_done;
      logic [CSR_DATA_BITS-1:0] width_data;
      logic [CSR_DATA_BITS-1:0] height_data;
      pixel_mix_type      mix;

      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_IMAGE_WIDTH;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.pixel_in <= '0;
      stall_pct        <= 0;
      send_gap_pct     = 0;
      width_set        = WIDTH_RESET;
      height_set       = HEIGHT_RESET;
      col_at           = 0;
      row_at           = 0;
      small_items      = 0;
      wide_done        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // all-white 3x3 frame: width field masked to zero and height zero, both clamped
      run_frame(12'h800, 12'd0, PIX_SATURATED);
      // tallest frame cut short by a height write in its fifth row
      reg_changes.push_back('{12, REG_IMAGE_HEIGHT, 12'd3});
      run_frame(12'd3, 12'hFFF, PIX_UNIFORM);

      while (small_items < 3 * PHASE_ITEMS) begin
         phase = small_items / PHASE_ITEMS;
         case (phase)
            0: begin
               send_gap_pct = 32;
               stall_pct   <= 71;
            end
            1: begin
               send_gap_pct = 71;
               stall_pct   <= 32;
            end
            default: begin
               send_gap_pct = 0;
               stall_pct   <= 0;
            end
         endcase
         if ($urandom_range(5) == 0) begin
            send_gap_pct = 0;
            stall_pct   <= 0;
         end

         if (phase == 2 && !wide_done) begin
            // widest line: clamp mid-line, reach the last store column, then shrink mid-frame
            reg_changes.push_back('{700, REG_IMAGE_WIDTH, 12'hFFF});
            reg_changes.push_back('{1024 + $urandom_range(4), REG_IMAGE_WIDTH,
                                    CSR_DATA_BITS'($urandom_range(8, 3))});
            run_frame(12'd1024, 12'd3, PIX_UNIFORM);
            wide_done = 1'b1;
         end

         if ($urandom_range(15) == 0) w_pick = $urandom_range(2);
         else if ($urandom_range(7) == 0) w_pick = $urandom_range(48, 13);
         else w_pick = $urandom_range(12, 3);
         if ($urandom_range(15) == 0) h_pick = $urandom_range(2);
         else h_pick = $urandom_range(7, 3);
         width_data  = CSR_DATA_BITS'(w_pick);
         height_data = CSR_DATA_BITS'(h_pick);
         if ($urandom_range(3) == 0) width_data[CSR_DATA_BITS-1] = 1'b1;

         if ($urandom_range(3) == 0) begin
            span = eff_width(width_data[WIDTH_BITS-1:0]) * eff_height(height_data);
            if ($urandom_range(1) == 1)
               reg_changes.push_back('{$urandom_range(span - 1, 1), REG_IMAGE_WIDTH,
                                       CSR_DATA_BITS'($urandom_range(16))});
            else
               reg_changes.push_back('{$urandom_range(span - 1, 1), REG_IMAGE_HEIGHT,
                                       CSR_DATA_BITS'($urandom_range(9))});
         end

         case ($urandom_range(7))
            0: mix = PIX_EXTREME;
            1: mix = PIX_BRIGHT;
            2: mix = PIX_DARK;
            default: mix = PIX_UNIFORM;
         endcase
         mark = items_sent;
         run_frame(width_data, height_data, mix);
         small_items += items_sent - mark;
      end

      drain();
      if (fail_count == 0) begin
         $display("box_filter_3x3_mean_unit verification clean");
      end else begin
         $display("box_filter_3x3_mean_unit verification failed");
      end
      $finish;
   end

endmodule
